// File: sv/fifo_page_replacement_core_macros.svh
// assertion macros for the fifo page replacement block
// used by the port checker; expects clk and rst in scope
`ifndef FIFO_PAGE_REPLACEMENT_CORE_MACROS_SVH
`define FIFO_PAGE_REPLACEMENT_CORE_MACROS_SVH

// antecedent holds in this cycle implies consequent in the same cycle
`define FPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds in this cycle implies consequent in the next cycle
`define FPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fpr_pkg.sv
// shared types, constants and helpers for the fifo page replacement block
// no dependencies
package fpr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int CNT_W      = FRAME_W + 1;
  localparam int FAULT_W    = 16;
  localparam int CFG_W      = 5;

  localparam logic [CNT_W-1:0]   MAX_FRAMES_C = CNT_W'(MAX_FRAMES);
  localparam logic [FAULT_W-1:0] FAULT_MAX    = {FAULT_W{1'b1}};
  localparam logic [CFG_W-1:0]   CFG_RESET    = CFG_W'(4);

  typedef struct packed {
    logic [15:0] page_number;
    logic        last_reference;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  frame_index;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [15:0] fault_total;
    logic        trace_end;
  } out_item_t;

  // sequencer to frame store
  typedef struct packed {
    logic [FRAME_W-1:0]   rd_addr;
    logic                 wr_en;
    logic [FRAME_W-1:0]   wr_addr;
    logic [PAGE_BITS-1:0] wr_data;
    logic                 clear;
  } store_ctrl_t;

  // frame store to sequencer, registered read
  typedef struct packed {
    logic [PAGE_BITS-1:0] rd_data;
    logic                 rd_valid;
  } store_resp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE
  } seq_state_t;

  // clamp the configured frame count into 1..MAX_FRAMES
  function automatic logic [CNT_W-1:0] active_frames(input logic [CFG_W-1:0] cfg);
    logic [CNT_W-1:0] n;
    n = CNT_W'(cfg);
    if (cfg == '0) begin
      n = CNT_W'(1);
    end else if (CNT_W'(cfg) > MAX_FRAMES_C || cfg > CFG_W'(MAX_FRAMES)) begin
      n = MAX_FRAMES_C;
    end
    return n;
  endfunction

endpackage

// File: sv/fpr_frame_store.sv
// page frame memory with per-frame valid flops
// depends on fpr_pkg
module fpr_frame_store
  import fpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  store_ctrl_t ctrl,
  output store_resp_t resp
);

  logic [PAGE_BITS-1:0] mem [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid;

  // page memory and valid flag, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= ctrl.wr_data;
    end
    resp.rd_data <= mem[ctrl.rd_addr];
    if (rst) begin
      resp.rd_valid <= 1'b0;
    end else begin
      resp.rd_valid <= valid[ctrl.rd_addr];
    end
  end

  // valid bits, a trace clear wins over a fill
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= '0;
    end else if (ctrl.wr_en) begin
      valid[ctrl.wr_addr] <= 1'b1;
    end
  end

endmodule

// File: sv/fpr_sequencer.sv
// scan sequencer: one frame compare per cycle, then a resolve state
// depends on fpr_pkg, drives fpr_frame_store through store_ctrl_t
module fpr_sequencer
  import fpr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  in_item_t         item,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  store_resp_t      resp,
  output store_ctrl_t      ctrl,
  output logic             busy,
  output logic             done,
  output out_item_t        result
);

  seq_state_t state, state_next;

  logic [CFG_W-1:0]     frames_in_use;
  logic [FRAME_W-1:0]   oldest_pointer;
  logic [FAULT_W-1:0]   fault_counter;

  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     n_act;
  logic [PAGE_BITS-1:0] page;
  logic                 last;
  logic                 found;
  logic [FRAME_W-1:0]   hit_slot;
  logic                 empty_found;
  logic [FRAME_W-1:0]   empty_slot;
  logic [FRAME_W-1:0]   victim;
  logic [PAGE_BITS-1:0] ev_page;

  logic [CNT_W-1:0]     n_start;
  logic [FRAME_W-1:0]   victim_start;
  logic                 accept;
  logic                 scan_last;
  logic [FRAME_W-1:0]   cmp_idx;
  logic                 cmp_hit;
  logic                 miss;
  logic                 evict;
  logic [FRAME_W-1:0]   slot;
  logic [FAULT_W-1:0]   fault_next;
  logic [CNT_W-1:0]     victim_inc;
  logic [FRAME_W-1:0]   pointer_next;
  out_item_t            result_next;

  assign accept       = start && (state == ST_IDLE);
  assign n_start      = active_frames(frames_in_use);
  assign victim_start = (CNT_W'(oldest_pointer) < n_start) ? oldest_pointer : '0;
  assign scan_last    = (cnt == n_act);
  assign cmp_idx      = cnt[FRAME_W-1:0] - FRAME_W'(1);
  assign cmp_hit      = (cnt != '0) && resp.rd_valid && (resp.rd_data == page);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (accept) state_next = ST_SCAN;
      ST_SCAN:    if (scan_last) state_next = ST_RESOLVE;
      ST_RESOLVE: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // resolve arithmetic: slot choice, fault count and pointer
  always_comb begin
    miss         = !found;
    evict        = miss && !empty_found;
    slot         = found ? hit_slot : (empty_found ? empty_slot : victim);
    fault_next   = (miss && fault_counter != FAULT_MAX) ? fault_counter + FAULT_W'(1)
                                                        : fault_counter;
    victim_inc   = CNT_W'(victim) + CNT_W'(1);
    pointer_next = (victim_inc < n_act) ? victim_inc[FRAME_W-1:0] : '0;
    result_next.hit           = found;
    result_next.frame_index   = 4'(slot);
    result_next.evicted_valid = evict;
    result_next.evicted_page  = evict ? 16'(ev_page) : '0;
    result_next.fault_total   = 16'(fault_next);
    result_next.trace_end     = last;
  end

  // outputs to the store and the handshake
  always_comb begin
    busy         = (state != ST_IDLE);
    ctrl.rd_addr = cnt[FRAME_W-1:0];
    ctrl.wr_en   = (state == ST_RESOLVE) && miss;
    ctrl.wr_addr = slot;
    ctrl.wr_data = page;
    ctrl.clear   = cfg_we || ((state == ST_RESOLVE) && last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_RESET;
    end else if (cfg_we) begin
      frames_in_use <= cfg_data;
    end
  end

  // replacement pointer and fault counter, cleared on reset, on a config write and at each trace end
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      oldest_pointer <= '0;
      fault_counter  <= '0;
    end else if (state == ST_RESOLVE) begin
      fault_counter <= fault_next;
      if (evict) begin
        oldest_pointer <= pointer_next;
      end
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      page        <= item.page_number;
      last        <= item.last_reference;
      n_act       <= n_start;
      victim      <= victim_start;
      cnt         <= '0;
      found       <= 1'b0;
      empty_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt != '0) begin
        if (cmp_hit && !found) begin
          found    <= 1'b1;
          hit_slot <= cmp_idx;
        end
        if (!resp.rd_valid && !empty_found) begin
          empty_found <= 1'b1;
          empty_slot  <= cmp_idx;
        end
        if (cmp_idx == victim) begin
          ev_page <= resp.rd_data;
        end
      end
    end
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_RESOLVE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESOLVE) begin
      result <= result_next;
    end
  end

endmodule

// File: sv/fifo_page_replacement_core.sv
// top level of the fifo page replacement block
// depends on fpr_pkg, fpr_frame_store and fpr_sequencer
//
// Usage:
//   Input channel: drive item and raise start; the item is taken at a clock
//   edge where start is high and busy is low. busy stays high while the item
//   is worked on.
//   Result channel: done is high for exactly one cycle with result valid;
//   the receiver must take it then, it cannot hold the block off.
//   Configuration: cfg_we with cfg_data writes frames_in_use (0 acts as 1,
//   above 16 acts as 16) and starts a new trace; write only while idle.
//   Operation: with n active frames the sequencer compares one frame per cycle
//   against the registered read of the page memory in its scan state, then
//   picks the slot in its resolve state; done is registered from the resolve
//   state, a new item can be taken in the done cycle, and no new item is
//   taken before the last one is through.
//   Reset: synchronous rst empties all frames, zeroes the replacement
//   pointer and fault count and sets frames_in_use to 4.
//   A result with trace_end set empties the frames for the next trace.
module fifo_page_replacement_core
  import fpr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  in_item_t         item,
  output logic             busy,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             done,
  output out_item_t        result
);

  store_ctrl_t ctrl;
  store_resp_t resp;

  fpr_frame_store u_store (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .resp (resp)
  );

  fpr_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .resp     (resp),
    .ctrl     (ctrl),
    .busy     (busy),
    .done     (done),
    .result   (result)
  );

endmodule

// File: sv/fpr_checker.sv
// port-level checker for fifo_page_replacement_core, attached by bind
// depends on fpr_pkg and fifo_page_replacement_core_macros.svh
`include "fifo_page_replacement_core_macros.svh"

module fpr_checker
  import fpr_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input in_item_t         item,
  input logic             busy,
  input logic             cfg_we,
  input logic [CFG_W-1:0] cfg_data,
  input logic             done,
  input out_item_t        result
);

  // an accepted item keeps the block busy in the next cycle
  `FPR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

  // a result is only shown once the block has finished its work
  `FPR_ASSERT_NOW(a_done_idle, done, !busy && $past(busy), "result strobe while busy")

  // a hit never displaces a page
  `FPR_ASSERT_NOW(a_hit_no_evict, done && result.hit, !result.evicted_valid,
                  "hit reported an eviction")

  // a fault is always counted and reports no stray evicted page
  `FPR_ASSERT_NOW(a_fault_counted, done && !result.hit,
                  result.fault_total != '0 && (result.evicted_valid || result.evicted_page == '0),
                  "fault result with zero count or stray evicted page")

endmodule

bind fifo_page_replacement_core fpr_checker u_fpr_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .item     (item),
  .busy     (busy),
  .cfg_we   (cfg_we),
  .cfg_data (cfg_data),
  .done     (done),
  .result   (result)
);
